// ===== src/extended_gcd_bezout_macros.svh =====
// Assertion macros shared by the extended GCD block.
`ifndef EXTENDED_GCD_BEZOUT_MACROS_SVH
`define EXTENDED_GCD_BEZOUT_MACROS_SVH

// Check a property on the rising clock, quiet while reset is asserted.
`define EGB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clock, reset included.
`define EGB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/egb_pkg.sv =====
// Package for the extended GCD block: default width and sequencer states.
package egb_pkg;

  // Default operand width in bits
  localparam int unsigned DATA_WIDTH_DEF = 31;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GROW,
    ST_SHRINK,
    ST_DONE
  } egb_state_t;

endpackage

// ===== src/egb_if.sv =====
// Valid/ready channel interfaces for operand and result words.
interface egb_in_if #(
  parameter int unsigned DATA_WIDTH = egb_pkg::DATA_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] first_value;
  logic [DATA_WIDTH-1:0] second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

interface egb_out_if #(
  parameter int unsigned DATA_WIDTH = egb_pkg::DATA_WIDTH_DEF
);
  logic                       valid;
  logic                       ready;
  logic        [DATA_WIDTH-1:0] divisor_result;
  logic signed [DATA_WIDTH:0]   coeff_first;
  logic signed [DATA_WIDTH:0]   coeff_second;

  modport source (output valid, output divisor_result, output coeff_first,
                  output coeff_second, input ready);
  modport sink   (input valid, input divisor_result, input coeff_first,
                  input coeff_second, output ready);
endinterface

// ===== src/extended_gcd_bezout.sv =====
// Extended Euclidean algorithm: gcd of two operands plus Bezout coefficients.
//
// Usage: an operand word (first_value a, second_value b) enters on in_ch when
// valid and ready are both high. One result word leaves on out_ch holding
// divisor_result = gcd(a, b) and signed coeff_first x, coeff_second y with
// a*x + b*y = gcd. b == 0 gives gcd = a, x = 1, y = 0 (both zero: gcd 0).
// in_ch.ready is high only while the sequencer is idle; one word is worked at
// a time. Each division step runs on one shared shift/subtract unit: the
// divisor is shifted up one place a cycle until it passes the remainder, then
// walked back down, subtracting (and updating both coefficient pairs) once a
// cycle. The sum of log2 q over the quotients q of a run is at most DATA_WIDTH.
// The result sits in an output register: the next word is accepted while it
// waits, and a stalled receiver only holds the sequencer at its final state.
// Reset (rst_n low, synchronous) empties the output register and returns the
// sequencer to idle.
module extended_gcd_bezout #(
  parameter int unsigned DATA_WIDTH = egb_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  egb_in_if.sink    in_ch,
  egb_out_if.source out_ch
);

  localparam int unsigned CW = DATA_WIDTH + 1;
  localparam int unsigned KW = (DATA_WIDTH > 2) ? $clog2(DATA_WIDTH) : 1;
  localparam logic [KW-1:0] K_MAX = KW'(DATA_WIDTH - 1);

  egb_pkg::egb_state_t state_r, state_nxt;

  // Remainder pair, coefficient pairs, shift count
  logic [DATA_WIDTH-1:0] r0_r, r0_nxt, r1_r, r1_nxt;
  logic [CW-1:0]         s0_r, s0_nxt, s1_r, s1_nxt;
  logic [CW-1:0]         t0_r, t0_nxt, t1_r, t1_nxt;
  logic [KW-1:0]         k_r, k_nxt;

  // Output register
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_gcd_r;
  logic [CW-1:0]         out_x_r, out_y_r;

  logic                  in_fire;
  logic                  out_load;
  logic                  grow_ok;
  logic                  sub_ok;
  logic [DATA_WIDTH-1:0] r0_grow_shr, r0_shr;
  logic [DATA_WIDTH-1:0] r_diff;
  logic [CW-1:0]         s_diff, t_diff;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == egb_pkg::ST_DONE) && (!out_valid_r || out_ch.ready);

  // Shared unit: compare divisor against shifted remainder, shifted subtract
  assign r0_grow_shr = r0_r >> (k_r + KW'(1));
  assign r0_shr      = r0_r >> k_r;
  assign grow_ok     = (k_r < K_MAX) && (r1_r <= r0_grow_shr);
  assign sub_ok      = (r1_r <= r0_shr);
  assign r_diff      = sub_ok ? (r0_r - (r1_r << k_r)) : r0_r;
  assign s_diff      = sub_ok ? (s0_r - (s1_r << k_r)) : s0_r;
  assign t_diff      = sub_ok ? (t0_r - (t1_r << k_r)) : t0_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      egb_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = egb_pkg::ST_CHECK;
      end
      egb_pkg::ST_CHECK: begin
        state_nxt = (r1_r == '0) ? egb_pkg::ST_DONE : egb_pkg::ST_GROW;
      end
      egb_pkg::ST_GROW: begin
        if (!grow_ok) state_nxt = egb_pkg::ST_SHRINK;
      end
      egb_pkg::ST_SHRINK: begin
        if (k_r == '0) state_nxt = egb_pkg::ST_CHECK;
      end
      egb_pkg::ST_DONE: begin
        if (out_load) state_nxt = egb_pkg::ST_IDLE;
      end
      default: state_nxt = egb_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates per state
  always_comb begin
    r0_nxt = r0_r;
    r1_nxt = r1_r;
    s0_nxt = s0_r;
    s1_nxt = s1_r;
    t0_nxt = t0_r;
    t1_nxt = t1_r;
    k_nxt  = k_r;
    unique case (state_r)
      egb_pkg::ST_IDLE: begin
        r0_nxt = in_ch.first_value;
        r1_nxt = in_ch.second_value;
        s0_nxt = CW'(1);
        s1_nxt = '0;
        t0_nxt = '0;
        t1_nxt = CW'(1);
      end
      egb_pkg::ST_CHECK: begin
        k_nxt = '0;
      end
      egb_pkg::ST_GROW: begin
        if (grow_ok) k_nxt = k_r + KW'(1);
      end
      egb_pkg::ST_SHRINK: begin
        if (k_r == '0) begin
          // quotient complete: rotate the pairs
          r0_nxt = r1_r;
          r1_nxt = r_diff;
          s0_nxt = s1_r;
          s1_nxt = s_diff;
          t0_nxt = t1_r;
          t1_nxt = t_diff;
        end else begin
          r0_nxt = r_diff;
          s0_nxt = s_diff;
          t0_nxt = t_diff;
          k_nxt  = k_r - KW'(1);
        end
      end
      egb_pkg::ST_DONE: begin
        k_nxt = k_r;
      end
      default: k_nxt = k_r;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= egb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath and output payload registers
  always_ff @(posedge clk) begin
    r0_r <= r0_nxt;
    r1_r <= r1_nxt;
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
    t0_r <= t0_nxt;
    t1_r <= t1_nxt;
    k_r  <= k_nxt;
    if (out_load) begin
      out_gcd_r <= r0_r;
      out_x_r   <= s0_r;
      out_y_r   <= t0_r;
    end
  end

  // Port outputs
  always_comb begin
    in_ch.ready           = (state_r == egb_pkg::ST_IDLE);
    out_ch.valid          = out_valid_r;
    out_ch.divisor_result = out_gcd_r;
    out_ch.coeff_first    = $signed(out_x_r);
    out_ch.coeff_second   = $signed(out_y_r);
  end

`include "extended_gcd_bezout_macros.svh"

  `EGB_ASSERT(a_accept_check, in_fire |=> state_r == egb_pkg::ST_CHECK, "accept did not start a run")
  `EGB_ASSERT(a_div_nonzero, (state_r == egb_pkg::ST_GROW || state_r == egb_pkg::ST_SHRINK) |-> r1_r != '0, "division by zero divisor")
  `EGB_ASSERT(a_shift_bound, state_r == egb_pkg::ST_SHRINK |-> k_r <= K_MAX, "shift count out of range")
  `EGB_ASSERT_ALWAYS(a_load_free, out_load |-> (!out_valid_r || out_ch.ready), "result overwrote a pending word")

endmodule
